>>> rtl/sfhd_pkg.sv
// Shared constants, types and helper functions of the symmetric flow hash dispatcher.
// Used by the channel interfaces, the controller, the datapath and the checker.
`timescale 1ns / 1ps
`default_nettype none

package sfhd_pkg;

   localparam int ADDR_WIDTH   = 32;
   localparam int PORT_WIDTH   = 16;
   localparam int PROTO_WIDTH  = 8;
   localparam int HASH_WIDTH   = 20;
   localparam int BUCKET_WIDTH = 8;
   localparam int COUNT_WIDTH  = 9;

   localparam logic [HASH_WIDTH-1:0]  HASH_MOD    = 20'd1000003;
   localparam logic [21:0]            HASH_MOD_X2 = 22'd2000006;
   localparam logic [10:0]            HASH_MULT   = 11'd1993;
   localparam logic [23:0]            HASH_RECIP  = 24'd8559844;
   localparam logic [HASH_WIDTH-1:0]  HASH_SEED   = 20'd1;

   localparam int TEXT_LEN    = 64;
   localparam int ADDR_DIGITS = 10;
   localparam int PORT_DIGITS = 5;
   localparam int NUM_DIGIT_FIELDS = 4;
   localparam int CONV_STEPS  = 32;
   localparam int DIV_STEPS   = 20;

   localparam logic [COUNT_WIDTH-1:0] MAX_BUCKETS        = 9'd256;
   localparam logic [COUNT_WIDTH-1:0] BUCKET_COUNT_RESET = 9'd10;

   localparam logic [2:0] FLD_LO_ADDR = 3'd0;
   localparam logic [2:0] FLD_HI_ADDR = 3'd1;
   localparam logic [2:0] FLD_LO_PORT = 3'd2;
   localparam logic [2:0] FLD_HI_PORT = 3'd3;
   localparam logic [2:0] FLD_PROTO   = 3'd4;
   localparam logic [2:0] FLD_PAD     = 3'd5;

   typedef logic [ADDR_DIGITS-1:0][3:0] addr_bcd_type;
   typedef logic [PORT_DIGITS-1:0][3:0] port_bcd_type;

   typedef struct packed {
      logic       load;
      logic       conv_step;
      logic       hash_init;
      logic       hash_mul;
      logic       hash_red;
      logic       div_init;
      logic       div_step;
      logic       rsp_load;
      logic [2:0] field;
      logic [3:0] digit;
   } cmd_type;

   typedef struct packed {
      logic [NUM_DIGIT_FIELDS-1:0][3:0] top;
   } status_type;

   // One shift-and-add-3 step of a binary to decimal conversion.
   function automatic addr_bcd_type dd_step(addr_bcd_type v, logic b);
      addr_bcd_type adj;
      logic [4*ADDR_DIGITS-1:0] flat;
      adj = v;
      for (int i = 0; i < ADDR_DIGITS; i++) begin
         if (v[i] >= 4'd5) begin
            adj[i] = v[i] + 4'd3;
         end
      end
      flat = adj;
      return {flat[4*ADDR_DIGITS-2:0], b};
   endfunction

   // Position of the most significant nonzero digit, zero when all digits are zero.
   function automatic logic [3:0] top_digit(addr_bcd_type v);
      logic [3:0] t;
      t = 4'd0;
      for (int i = 0; i < ADDR_DIGITS; i++) begin
         if (v[i] != 4'd0) begin
            t = 4'(i);
         end
      end
      return t;
   endfunction

endpackage

`default_nettype wire

>>> rtl/sfhd_req_if.sv
// Request channel interface: valid, ready and the flow five-tuple word.
// Depends on sfhd_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface sfhd_req_if;
   import sfhd_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [ADDR_WIDTH-1:0]  source_address;
   logic [ADDR_WIDTH-1:0]  dest_address;
   logic [PORT_WIDTH-1:0]  source_port;
   logic [PORT_WIDTH-1:0]  dest_port;
   logic [PROTO_WIDTH-1:0] protocol_number;

   modport source (
      output valid, source_address, dest_address, source_port, dest_port, protocol_number,
      input  ready
   );
   modport sink (
      input  valid, source_address, dest_address, source_port, dest_port, protocol_number,
      output ready
   );
endinterface

`default_nettype wire

>>> rtl/sfhd_rsp_if.sv
// Response channel interface: valid, ready and the hash and bucket word.
// Depends on sfhd_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface sfhd_rsp_if;
   import sfhd_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [HASH_WIDTH-1:0]   flow_hash;
   logic [BUCKET_WIDTH-1:0] bucket_index;

   modport source (
      output valid, flow_hash, bucket_index,
      input  ready
   );
   modport sink (
      input  valid, flow_hash, bucket_index,
      output ready
   );
endinterface

`default_nettype wire

>>> rtl/sfhd_ctrl.sv
// Controller state machine: sequences conversion, hashing, remainder and response.
// Depends on sfhd_pkg for the command and status structs and the field codes.
`timescale 1ns / 1ps
`default_nettype none

module sfhd_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               rsp_ready,
   output logic                    rsp_valid,
   output sfhd_pkg::cmd_type       cmd,
   input  wire sfhd_pkg::status_type status
);
   import sfhd_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CONV  = 3'd1;
   localparam logic [2:0] ST_START = 3'd2;
   localparam logic [2:0] ST_MUL   = 3'd3;
   localparam logic [2:0] ST_RED   = 3'd4;
   localparam logic [2:0] ST_DVI   = 3'd5;
   localparam logic [2:0] ST_DIV   = 3'd6;
   localparam logic [2:0] ST_FIN   = 3'd7;

   logic [2:0] state_ff, state_in;
   logic [4:0] step_ff, step_in;
   logic [5:0] byte_ff, byte_in;
   logic [2:0] field_ff, field_in;
   logic [3:0] digit_ff, digit_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      byte_in   = byte_ff;
      field_in  = field_ff;
      digit_in  = digit_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.field = field_ff;
      cmd.digit = digit_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               step_in  = 5'd0;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            cmd.conv_step = 1'b1;
            step_in       = step_ff + 5'd1;
            if (step_ff == 5'(CONV_STEPS - 1)) begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            cmd.hash_init = 1'b1;
            field_in      = FLD_LO_ADDR;
            digit_in      = status.top[0];
            byte_in       = 6'd0;
            state_in      = ST_MUL;
         end
         ST_MUL: begin
            cmd.hash_mul = 1'b1;
            state_in     = ST_RED;
            if (field_ff == FLD_PROTO) begin
               field_in = FLD_PAD;
            end else if (field_ff != FLD_PAD) begin
               if (digit_ff != 4'd0) begin
                  digit_in = digit_ff - 4'd1;
               end else if (field_ff == FLD_HI_PORT) begin
                  field_in = FLD_PROTO;
                  digit_in = 4'd0;
               end else begin
                  field_in = field_ff + 3'd1;
                  digit_in = status.top[field_ff[1:0] + 2'd1];
               end
            end
         end
         ST_RED: begin
            cmd.hash_red = 1'b1;
            byte_in      = byte_ff + 6'd1;
            if (byte_ff == 6'(TEXT_LEN - 1)) begin
               state_in = ST_DVI;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_DVI: begin
            cmd.div_init = 1'b1;
            step_in      = 5'd0;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 5'd1;
            if (step_ff == 5'(DIV_STEPS - 1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= 5'd0;
         byte_ff      <= 6'd0;
         field_ff     <= FLD_LO_ADDR;
         digit_ff     <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         byte_ff      <= byte_in;
         field_ff     <= field_in;
         digit_ff     <= digit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

>>> rtl/sfhd_datapath.sv
// Datapath: tuple ordering, decimal conversion, multiply-reduce hash, remainder unit,
// bucket count register and response register. Depends on sfhd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sfhd_datapath (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire sfhd_pkg::cmd_type                 cmd,
   output sfhd_pkg::status_type                   status,
   input  wire logic [sfhd_pkg::ADDR_WIDTH-1:0]   source_address,
   input  wire logic [sfhd_pkg::ADDR_WIDTH-1:0]   dest_address,
   input  wire logic [sfhd_pkg::PORT_WIDTH-1:0]   source_port,
   input  wire logic [sfhd_pkg::PORT_WIDTH-1:0]   dest_port,
   input  wire logic [sfhd_pkg::PROTO_WIDTH-1:0]  protocol_number,
   input  wire logic                              csr_wr_en,
   input  wire logic [sfhd_pkg::COUNT_WIDTH-1:0]  csr_wr_data,
   output logic [sfhd_pkg::HASH_WIDTH-1:0]        flow_hash,
   output logic [sfhd_pkg::BUCKET_WIDTH-1:0]      bucket_index
);
   import sfhd_pkg::*;

   logic [ADDR_WIDTH-1:0]   lo_bin_ff, lo_bin_in, hi_bin_ff, hi_bin_in;
   logic [ADDR_WIDTH-1:0]   lo_pbin_ff, lo_pbin_in, hi_pbin_ff, hi_pbin_in;
   logic [PROTO_WIDTH-1:0]  proto_ff, proto_in;
   addr_bcd_type            lo_bcd_ff, lo_bcd_in, hi_bcd_ff, hi_bcd_in;
   port_bcd_type            lo_pbcd_ff, lo_pbcd_in, hi_pbcd_ff, hi_pbcd_in;
   addr_bcd_type            lo_ptmp, hi_ptmp;
   logic [HASH_WIDTH-1:0]   h_ff, h_in;
   logic [30:0]             x_ff, x_in;
   logic [10:0]             q_ff, q_in;
   logic [43:0]             q_prod;
   logic [30:0]             qp, r_full;
   logic [21:0]             r_lo;
   logic [7:0]              text_byte;
   logic [COUNT_WIDTH-1:0]  count_ff, count_in, eff_count;
   logic [COUNT_WIDTH-1:0]  rem_ff, rem_in, dvs_ff, dvs_in;
   logic [COUNT_WIDTH:0]    trial;
   logic [HASH_WIDTH-1:0]   dvd_ff, dvd_in;
   logic                    zero_ff, zero_in, swap;
   logic [HASH_WIDTH-1:0]   flow_hash_ff, flow_hash_in;
   logic [BUCKET_WIDTH-1:0] bucket_ff, bucket_in;

   always_comb begin
      swap     = source_address > dest_address;
      lo_ptmp  = dd_step({{(4*(ADDR_DIGITS-PORT_DIGITS)){1'b0}}, lo_pbcd_ff}, lo_pbin_ff[31]);
      hi_ptmp  = dd_step({{(4*(ADDR_DIGITS-PORT_DIGITS)){1'b0}}, hi_pbcd_ff}, hi_pbin_ff[31]);

      lo_bin_in  = lo_bin_ff;
      hi_bin_in  = hi_bin_ff;
      lo_pbin_in = lo_pbin_ff;
      hi_pbin_in = hi_pbin_ff;
      proto_in   = proto_ff;
      lo_bcd_in  = lo_bcd_ff;
      hi_bcd_in  = hi_bcd_ff;
      lo_pbcd_in = lo_pbcd_ff;
      hi_pbcd_in = hi_pbcd_ff;
      if (cmd.load) begin
         lo_bin_in  = swap ? dest_address : source_address;
         hi_bin_in  = swap ? source_address : dest_address;
         lo_pbin_in = ADDR_WIDTH'(swap ? dest_port : source_port);
         hi_pbin_in = ADDR_WIDTH'(swap ? source_port : dest_port);
         proto_in   = protocol_number;
         lo_bcd_in  = '0;
         hi_bcd_in  = '0;
         lo_pbcd_in = '0;
         hi_pbcd_in = '0;
      end else if (cmd.conv_step) begin
         lo_bin_in  = {lo_bin_ff[ADDR_WIDTH-2:0], 1'b0};
         hi_bin_in  = {hi_bin_ff[ADDR_WIDTH-2:0], 1'b0};
         lo_pbin_in = {lo_pbin_ff[ADDR_WIDTH-2:0], 1'b0};
         hi_pbin_in = {hi_pbin_ff[ADDR_WIDTH-2:0], 1'b0};
         lo_bcd_in  = dd_step(lo_bcd_ff, lo_bin_ff[ADDR_WIDTH-1]);
         hi_bcd_in  = dd_step(hi_bcd_ff, hi_bin_ff[ADDR_WIDTH-1]);
         lo_pbcd_in = lo_ptmp[PORT_DIGITS-1:0];
         hi_pbcd_in = hi_ptmp[PORT_DIGITS-1:0];
      end

      status.top[FLD_LO_ADDR[1:0]] = top_digit(lo_bcd_ff);
      status.top[FLD_HI_ADDR[1:0]] = top_digit(hi_bcd_ff);
      status.top[FLD_LO_PORT[1:0]] =
         top_digit({{(4*(ADDR_DIGITS-PORT_DIGITS)){1'b0}}, lo_pbcd_ff});
      status.top[FLD_HI_PORT[1:0]] =
         top_digit({{(4*(ADDR_DIGITS-PORT_DIGITS)){1'b0}}, hi_pbcd_ff});

      case (cmd.field)
         FLD_LO_ADDR: text_byte = {4'h3, lo_bcd_ff[cmd.digit]};
         FLD_HI_ADDR: text_byte = {4'h3, hi_bcd_ff[cmd.digit]};
         FLD_LO_PORT: text_byte = {4'h3, lo_pbcd_ff[cmd.digit[2:0]]};
         FLD_HI_PORT: text_byte = {4'h3, hi_pbcd_ff[cmd.digit[2:0]]};
         FLD_PROTO:   text_byte = proto_ff;
         default:     text_byte = 8'd0;
      endcase

      // The quotient estimate comes from h alone and is low by at most two.
      x_in   = x_ff;
      q_in   = q_ff;
      q_prod = 44'(h_ff) * 44'(HASH_RECIP);
      if (cmd.hash_mul) begin
         x_in = 31'(h_ff) * 31'(HASH_MULT) + 31'(text_byte);
         q_in = q_prod[42:32];
      end
      qp     = 31'(q_ff) * 31'(HASH_MOD);
      r_full = x_ff - qp;
      r_lo   = r_full[21:0];
      h_in   = h_ff;
      if (cmd.hash_init) begin
         h_in = HASH_SEED;
      end else if (cmd.hash_red) begin
         if (r_lo >= HASH_MOD_X2) begin
            h_in = 20'(r_lo - HASH_MOD_X2);
         end else if (r_lo >= 22'(HASH_MOD)) begin
            h_in = 20'(r_lo - 22'(HASH_MOD));
         end else begin
            h_in = r_lo[HASH_WIDTH-1:0];
         end
      end

      count_in  = csr_wr_en ? csr_wr_data : count_ff;
      eff_count = (count_ff > MAX_BUCKETS) ? MAX_BUCKETS : count_ff;

      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      zero_in = zero_ff;
      trial   = {rem_ff, dvd_ff[HASH_WIDTH-1]};
      if (cmd.div_init) begin
         rem_in  = '0;
         dvd_in  = h_ff;
         dvs_in  = eff_count;
         zero_in = eff_count == '0;
      end else if (cmd.div_step) begin
         dvd_in = {dvd_ff[HASH_WIDTH-2:0], 1'b0};
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = COUNT_WIDTH'(trial - {1'b0, dvs_ff});
         end else begin
            rem_in = trial[COUNT_WIDTH-1:0];
         end
      end

      flow_hash_in = flow_hash_ff;
      bucket_in    = bucket_ff;
      if (cmd.rsp_load) begin
         flow_hash_in = h_ff;
         bucket_in    = zero_ff ? '0 : rem_ff[BUCKET_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= BUCKET_COUNT_RESET;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_bin_ff    <= lo_bin_in;
      hi_bin_ff    <= hi_bin_in;
      lo_pbin_ff   <= lo_pbin_in;
      hi_pbin_ff   <= hi_pbin_in;
      proto_ff     <= proto_in;
      lo_bcd_ff    <= lo_bcd_in;
      hi_bcd_ff    <= hi_bcd_in;
      lo_pbcd_ff   <= lo_pbcd_in;
      hi_pbcd_ff   <= hi_pbcd_in;
      h_ff         <= h_in;
      x_ff         <= x_in;
      q_ff         <= q_in;
      rem_ff       <= rem_in;
      dvd_ff       <= dvd_in;
      dvs_ff       <= dvs_in;
      zero_ff      <= zero_in;
      flow_hash_ff <= flow_hash_in;
      bucket_ff    <= bucket_in;
   end

   assign flow_hash    = flow_hash_ff;
   assign bucket_index = bucket_ff;

endmodule

`default_nettype wire

>>> rtl/symmetric_flow_hash_dispatch.sv
// A request word is taken only in the idle state, so one word is processed at a time;
// each passes through the 32-step decimal conversion, the 64 multiply-reduce rounds
// of the hash unit and the 20-step remainder unit before its result is loaded.
// A finished result waits in the output register while the next request is taken.
// Reset is synchronous and active high; it clears control state and sets the bucket
// count to 10.
`timescale 1ns / 1ps
`default_nettype none

module symmetric_flow_hash_dispatch (
   input  wire logic                             clock,
   input  wire logic                             reset,
   sfhd_req_if.sink                              req_bus,
   sfhd_rsp_if.source                            rsp_bus,
   input  wire logic                             csr_wr_en,
   input  wire logic [sfhd_pkg::COUNT_WIDTH-1:0] csr_wr_data
);
   import sfhd_pkg::*;

   cmd_type    cmd;
   status_type status;

   sfhd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_ready (rsp_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .cmd       (cmd),
      .status    (status)
   );

   sfhd_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .source_address  (req_bus.source_address),
      .dest_address    (req_bus.dest_address),
      .source_port     (req_bus.source_port),
      .dest_port       (req_bus.dest_port),
      .protocol_number (req_bus.protocol_number),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .flow_hash       (rsp_bus.flow_hash),
      .bucket_index    (rsp_bus.bucket_index)
   );

endmodule

`default_nettype wire

>>> rtl/sfhd_checker.sv
// Port-level checker for the dispatcher and the bind that attaches it to the top level.
// Depends on sfhd_pkg for the hash modulus and field widths.
`timescale 1ns / 1ps
`default_nettype none

module sfhd_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_valid,
   input wire logic                              req_ready,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_ready,
   input wire logic [sfhd_pkg::HASH_WIDTH-1:0]   rsp_flow_hash,
   input wire logic [sfhd_pkg::BUCKET_WIDTH-1:0] rsp_bucket_index
);
   import sfhd_pkg::*;

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_flow_hash) && $stable(rsp_bucket_index))
      else $error("response word changed while stalled");

   a_hash_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_flow_hash < HASH_MOD)
      else $error("flow hash not reduced");

   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_valid && req_ready))
      else $error("response appeared right after a request was taken");

endmodule

bind symmetric_flow_hash_dispatch sfhd_checker u_sfhd_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_bus.valid),
   .req_ready        (req_bus.ready),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_flow_hash    (rsp_bus.flow_hash),
   .rsp_bucket_index (rsp_bus.bucket_index)
);

`default_nettype wire
